// ----- src/sbh_pkg.sv -----
// Shared widths, constants, control structs and helpers for the swept box hit block.
// No dependencies; every other file in src imports this package.
`default_nettype none

package sbh_pkg;

  // Default number of fraction bits on the Q-format position ports
  localparam int FRAC_BITS_DEF = 8;

  // Port field widths
  localparam int POS_W   = 24;
  localparam int SIZE_W  = 23;
  localparam int VEL_W   = 24;
  localparam int BPOS_W  = 16;
  localparam int BSIZE_W = 15;
  localparam int DT_W    = 16;
  localparam int CT_W    = 24;
  localparam int NRM_W   = 2;
  localparam int TIME_W  = 24;

  // Internal widths
  localparam int DIR_W     = VEL_W + DT_W;   // direction = velocity * step
  localparam int UD_W      = DIR_W - 1;      // magnitude of the direction
  localparam int TQ_FRAC   = 31;             // fraction bits of a raw slab time
  localparam int SLAB_W    = 64;             // signed slab time incl. infinities
  localparam int SAT_SHIFT = 60;             // slab times saturate at 2^60
  localparam int TC_W      = TIME_W + 1;     // clamped entry time, +-2^23
  localparam int DLO_W     = 20;             // low slice of the direction multiply

  localparam logic signed [SLAB_W-1:0] T_BIG    = 64'sh1000_0000_0000_0000;
  localparam logic signed [SLAB_W-1:0] T_INF    = 64'sh4000_0000_0000_0000;
  localparam logic signed [SLAB_W-1:0] TIME_MIN = -64'sd8388608;
  localparam logic signed [SLAB_W-1:0] TIME_MAX = 64'sd8388607;
  localparam logic signed [SLAB_W-1:0] TC_MAX   = 64'sd8388608;
  localparam logic signed [SLAB_W-1:0] HIT_LIM  = 64'sd65536;

  // Normal codes
  localparam logic [NRM_W-1:0] NRM_ZERO = 2'b00;
  localparam logic [NRM_W-1:0] NRM_POS  = 2'b01;
  localparam logic [NRM_W-1:0] NRM_NEG  = 2'b11;

  // Per-axis sign and zero flags that travel beside the dividers
  typedef struct packed {
    logic vneg;
    logic dneg;
    logic dzero;
    logic a_neg;
    logic a_zero;
    logic b_neg;
    logic b_zero;
  } axis_flags_t;

  typedef struct packed {
    logic        valid;
    logic        vzero;
    axis_flags_t ax;
    axis_flags_t ay;
  } item_ctl_t;

  // Width of the slab numerators for a given fraction count
  function automatic int num_width(input int f);
    return (f + 20 > 28) ? f + 20 : 28;
  endfunction

endpackage

`default_nettype wire

// ----- src/sbh_front.sv -----
// Front end: grown box, centre, direction multiply and slab numerators, four stages.
// Depends on sbh_pkg.
`default_nettype none

module sbh_front import sbh_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int NUM_W     = num_width(FRAC_BITS_DEF)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic signed [POS_W-1:0]  mover_x,
  input  wire logic signed [POS_W-1:0]  mover_y,
  input  wire logic [SIZE_W-1:0]        mover_w,
  input  wire logic [SIZE_W-1:0]        mover_h,
  input  wire logic signed [VEL_W-1:0]  vel_x,
  input  wire logic signed [VEL_W-1:0]  vel_y,
  input  wire logic signed [BPOS_W-1:0] box_x,
  input  wire logic signed [BPOS_W-1:0] box_y,
  input  wire logic [BSIZE_W-1:0]       box_w,
  input  wire logic [BSIZE_W-1:0]       box_h,
  input  wire logic [DT_W-1:0]          step_time,
  output item_ctl_t                     ctl_o,
  output logic [NUM_W-1:0]              un_a_o [2],
  output logic [NUM_W-1:0]              un_b_o [2],
  output logic [UD_W-1:0]               ud_o   [2],
  output logic signed [NUM_W-1:0]       o2_o   [2],
  output logic signed [DIR_W-1:0]       d_o    [2]
);

  localparam int SH = FRAC_BITS + 1;

  // lane views of the inputs (lane 0 = x, lane 1 = y)
  logic signed [POS_W-1:0]  pos   [2];
  logic [SIZE_W-1:0]        size  [2];
  logic signed [VEL_W-1:0]  vel   [2];
  logic signed [BPOS_W-1:0] bpos  [2];
  logic [BSIZE_W-1:0]       bsize [2];

  assign pos[0]   = mover_x;
  assign pos[1]   = mover_y;
  assign size[0]  = mover_w;
  assign size[1]  = mover_h;
  assign vel[0]   = vel_x;
  assign vel[1]   = vel_y;
  assign bpos[0]  = box_x;
  assign bpos[1]  = box_y;
  assign bsize[0] = box_w;
  assign bsize[1] = box_h;

  // stage A: corner offset, doubled centre, grown size, direction
  logic                     va_r, vza_r;
  logic signed [NUM_W-1:0]  va_v_r   [2];
  logic signed [NUM_W-1:0]  va_o2_r  [2];
  logic [NUM_W-1:0]         va_csz_r [2];
  logic signed [DIR_W-1:0]  va_d_r   [2];
  logic                     va_vn_r  [2];
  logic signed [DIR_W:0]    prod     [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod[i] = vel[i] * $signed({1'b0, step_time});
    end
  end

  // stage B: corner truncated toward zero, grown far edge minus centre
  logic                     vb_r, vzb_r;
  logic signed [NUM_W-1:0]  vb_cps_r [2];
  logic signed [NUM_W-1:0]  vb_w_r   [2];
  logic signed [NUM_W-1:0]  vb_o2_r  [2];
  logic signed [DIR_W-1:0]  vb_d_r   [2];
  logic                     vb_vn_r  [2];
  logic                     corr     [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      corr[i] = va_v_r[i][NUM_W-1] && (va_v_r[i][SH-1:0] != '0);
    end
  end

  // stage C: slab numerators
  logic                     vc_r, vzc_r;
  logic signed [NUM_W-1:0]  vc_na_r [2];
  logic signed [NUM_W-1:0]  vc_nb_r [2];
  logic signed [NUM_W-1:0]  vc_o2_r [2];
  logic signed [DIR_W-1:0]  vc_d_r  [2];
  logic                     vc_vn_r [2];

  // stage D: magnitudes and flags
  item_ctl_t                ctl_r;
  axis_flags_t              axf [2];
  logic [DIR_W-1:0]         dmag [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      axf[i].vneg   = vc_vn_r[i];
      axf[i].dneg   = vc_d_r[i][DIR_W-1];
      axf[i].dzero  = (vc_d_r[i] == '0);
      axf[i].a_neg  = vc_na_r[i][NUM_W-1];
      axf[i].a_zero = (vc_na_r[i] == '0);
      axf[i].b_neg  = vc_nb_r[i][NUM_W-1];
      axf[i].b_zero = (vc_nb_r[i] == '0);
      dmag[i] = vc_d_r[i][DIR_W-1] ? DIR_W'(-vc_d_r[i]) : vc_d_r[i];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      ctl_r.valid <= 1'b0;
    end else begin
      va_r        <= in_valid;
      vb_r        <= va_r;
      vc_r        <= vb_r;
      ctl_r.valid <= vc_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    vza_r <= (vel_x == '0) && (vel_y == '0);
    vzb_r <= vza_r;
    vzc_r <= vzb_r;
    ctl_r.vzero <= vzc_r;
    ctl_r.ax    <= axf[0];
    ctl_r.ay    <= axf[1];
    for (int i = 0; i < 2; i++) begin
      va_v_r[i]   <= (NUM_W'(bpos[i]) <<< SH) - NUM_W'(size[i]);
      va_o2_r[i]  <= (NUM_W'(pos[i]) <<< 1) + NUM_W'(size[i]);
      va_csz_r[i] <= NUM_W'(bsize[i]) + NUM_W'(size[i] >> FRAC_BITS);
      va_d_r[i]   <= prod[i][DIR_W-1:0];
      va_vn_r[i]  <= vel[i][VEL_W-1];

      vb_cps_r[i] <= ((va_v_r[i] >>> SH) + NUM_W'(corr[i])) <<< SH;
      vb_w_r[i]   <= (va_csz_r[i] << SH) - va_o2_r[i];
      vb_o2_r[i]  <= va_o2_r[i];
      vb_d_r[i]   <= va_d_r[i];
      vb_vn_r[i]  <= va_vn_r[i];

      vc_na_r[i]  <= vb_cps_r[i] - vb_o2_r[i];
      vc_nb_r[i]  <= vb_cps_r[i] + vb_w_r[i];
      vc_o2_r[i]  <= vb_o2_r[i];
      vc_d_r[i]   <= vb_d_r[i];
      vc_vn_r[i]  <= vb_vn_r[i];

      un_a_o[i] <= vc_na_r[i][NUM_W-1] ? NUM_W'(-vc_na_r[i]) : vc_na_r[i];
      un_b_o[i] <= vc_nb_r[i][NUM_W-1] ? NUM_W'(-vc_nb_r[i]) : vc_nb_r[i];
      ud_o[i]   <= dmag[i][UD_W-1:0];
      o2_o[i]   <= vc_o2_r[i];
      d_o[i]    <= vc_d_r[i];
    end
  end

  assign ctl_o = ctl_r;

endmodule

`default_nettype wire

// ----- src/sbh_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: floor(un * 2^31 / ud).
// Depends on sbh_pkg.
`default_nettype none

module sbh_div import sbh_pkg::*; #(
  parameter int NUM_W = num_width(FRAC_BITS_DEF),
  parameter int QW    = num_width(FRAC_BITS_DEF) + TQ_FRAC
) (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] un_i,
  input  wire logic [UD_W-1:0]  ud_i,
  output logic [QW-1:0]         quo_o,
  output logic                  rem_nz_o
);

  logic [NUM_W-1:0] un_r  [QW];
  logic [UD_W-1:0]  ud_r  [QW];
  logic [UD_W-1:0]  rem_r [QW];
  logic [QW-1:0]    quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NUM_W-1:0] un_p;
    logic [UD_W-1:0]  ud_p;
    logic [UD_W-1:0]  rem_p;
    logic [QW-1:0]    quo_p;
    logic             dbit;
    logic [UD_W:0]    trial;
    logic             ge;

    if (k == 0) begin : g_head
      assign un_p  = un_i;
      assign ud_p  = ud_i;
      assign rem_p = '0;
      assign quo_p = '0;
    end else begin : g_body
      assign un_p  = un_r[k-1];
      assign ud_p  = ud_r[k-1];
      assign rem_p = rem_r[k-1];
      assign quo_p = quo_r[k-1];
    end

    // dividend bits MSB first, then the fraction zeros
    if (k < NUM_W) begin : g_bit
      assign dbit = un_p[NUM_W-1-k];
    end else begin : g_frac
      assign dbit = 1'b0;
    end

    assign trial = {rem_p, dbit};
    assign ge    = (trial >= {1'b0, ud_p});

    always_ff @(posedge clk) begin
      un_r[k]  <= un_p;
      ud_r[k]  <= ud_p;
      rem_r[k] <= ge ? UD_W'(trial - {1'b0, ud_p}) : trial[UD_W-1:0];
      quo_r[k] <= {quo_p[QW-2:0], ge};
    end
  end

  assign quo_o    = quo_r[QW-1];
  assign rem_nz_o = (rem_r[QW-1] != '0);

endmodule

`default_nettype wire

// ----- src/sbh_back.sv -----
// Back end: slab times, overlap and entry test, clamps, contact multiply; six stages.
// Depends on sbh_pkg.
`default_nettype none

module sbh_back import sbh_pkg::*; #(
  parameter int NUM_W = num_width(FRAC_BITS_DEF),
  parameter int QW    = num_width(FRAC_BITS_DEF) + TQ_FRAC
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire item_ctl_t               ctl_i,
  input  wire logic [QW-1:0]           qa_i   [2],
  input  wire logic                    ra_i   [2],
  input  wire logic [QW-1:0]           qb_i   [2],
  input  wire logic                    rb_i   [2],
  input  wire logic signed [NUM_W-1:0] o2_i   [2],
  input  wire logic signed [DIR_W-1:0] d_i    [2],
  output logic                         out_valid,
  output logic                         out_hit,
  output logic signed [CT_W-1:0]       out_contact_x,
  output logic signed [CT_W-1:0]       out_contact_y,
  output logic signed [NRM_W-1:0]      out_normal_x,
  output logic signed [NRM_W-1:0]      out_normal_y,
  output logic signed [TIME_W-1:0]     out_entry_time
);

  localparam int PLO_W  = TC_W + DLO_W + 1;
  localparam int PHI_W  = TC_W + DIR_W - DLO_W;
  localparam int PROD_W = TC_W + DIR_W;
  localparam int SH_W   = PROD_W - TQ_FRAC;
  localparam int CS_W   = ((NUM_W > SH_W) ? NUM_W : SH_W) + 1;
  localparam logic signed [CS_W-1:0] CT_MIN = CS_W'(-64'sd8388608);
  localparam logic signed [CS_W-1:0] CT_MAX = CS_W'(64'sd8388607);

  // signed slab time from an unsigned quotient; top bit flags zero over zero
  function automatic logic [SLAB_W:0] slab_t(input logic [QW-1:0] q, input logic rnz,
                                              input logic nneg, input logic nzero,
                                              input axis_flags_t f);
    logic              sat;
    logic [SLAB_W-1:0] mag;
    logic [SLAB_W-1:0] res;
    logic              nan;
    sat = ((q >> SAT_SHIFT) != '0);
    mag = sat ? T_BIG : SLAB_W'(q);
    nan = 1'b0;
    if (f.dzero) begin
      nan = nzero;
      res = nzero ? '0 : ((nneg != f.vneg) ? -T_INF : T_INF);
    end else if (nneg != f.dneg) begin
      res = -(mag + SLAB_W'(rnz && !sat));
    end else begin
      res = mag;
    end
    return {nan, res};
  endfunction

  // stage 1: slab times, sorted per axis
  axis_flags_t              fl [2];
  logic [SLAB_W:0]          sa [2];
  logic [SLAB_W:0]          sb [2];
  logic                     v1_r, vz1_r, nan1_r;
  logic signed [SLAB_W-1:0] tn1_r [2];
  logic signed [SLAB_W-1:0] tf1_r [2];
  logic                     vn1_r [2];
  logic signed [NUM_W-1:0]  o21_r [2];
  logic signed [DIR_W-1:0]  d1_r  [2];

  assign fl[0] = ctl_i.ax;
  assign fl[1] = ctl_i.ay;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sa[i] = slab_t(qa_i[i], ra_i[i], fl[i].a_neg, fl[i].a_zero, fl[i]);
      sb[i] = slab_t(qb_i[i], rb_i[i], fl[i].b_neg, fl[i].b_zero, fl[i]);
    end
  end

  // stage 2: overlap test, entry and exit times
  logic                     v2_r, rej2_r, gt2_r, lt2_r;
  logic signed [SLAB_W-1:0] hn2_r, hf2_r;
  logic                     vn2_r [2];
  logic signed [NUM_W-1:0]  o22_r [2];
  logic signed [DIR_W-1:0]  d2_r  [2];

  // stage 3: clamps, hit window, normals
  logic                     v3_r, keep3_r, hit3_r;
  logic [NRM_W-1:0]         nx3_r, ny3_r;
  logic [TIME_W-1:0]        tm3_r;
  logic signed [TC_W-1:0]   tc3_r;
  logic signed [NUM_W-1:0]  o23_r [2];
  logic signed [DIR_W-1:0]  d3_r  [2];
  logic                     keep3;
  logic [TIME_W-1:0]        tout;
  logic [TC_W-1:0]          tc;

  always_comb begin
    keep3 = !rej2_r && !hf2_r[SLAB_W-1];
    if (hn2_r < TIME_MIN) begin
      tout = TIME_W'(TIME_MIN);
      tc   = TC_W'(TIME_MIN);
    end else if (hn2_r > TIME_MAX) begin
      tout = TIME_W'(TIME_MAX);
      tc   = (hn2_r > TC_MAX) ? TC_W'(TC_MAX) : TC_W'(hn2_r);
    end else begin
      tout = TIME_W'(hn2_r);
      tc   = TC_W'(hn2_r);
    end
  end

  // stage 4: split direction multiply
  logic                     v4_r, keep4_r, hit4_r;
  logic [NRM_W-1:0]         nx4_r, ny4_r;
  logic [TIME_W-1:0]        tm4_r;
  logic signed [PLO_W-1:0]  plo4_r [2];
  logic signed [PHI_W-1:0]  phi4_r [2];
  logic signed [NUM_W-1:0]  o24_r  [2];

  // stage 5: product recombined, floored to the centre grid
  logic                     v5_r, keep5_r, hit5_r;
  logic [NRM_W-1:0]         nx5_r, ny5_r;
  logic [TIME_W-1:0]        tm5_r;
  logic signed [SH_W-1:0]   sh5_r  [2];
  logic signed [NUM_W-1:0]  o25_r  [2];
  logic signed [PROD_W-1:0] prod   [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod[i] = (PROD_W'(phi4_r[i]) <<< DLO_W) + PROD_W'(plo4_r[i]);
    end
  end

  // stage 6: contact point, floored to Q.F and saturated
  logic signed [CS_W-1:0]   csum [2];
  logic signed [CS_W-1:0]   chalf [2];
  logic [CT_W-1:0]          cclp [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      csum[i]  = CS_W'(o25_r[i]) + CS_W'(sh5_r[i]);
      chalf[i] = csum[i] >>> 1;
      if (chalf[i] < CT_MIN) begin
        cclp[i] = CT_W'(CT_MIN);
      end else if (chalf[i] > CT_MAX) begin
        cclp[i] = CT_W'(CT_MAX);
      end else begin
        cclp[i] = CT_W'(chalf[i]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1_r      <= ctl_i.valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      out_valid <= v5_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    vz1_r  <= ctl_i.vzero;
    nan1_r <= sa[0][SLAB_W] | sb[0][SLAB_W] | sa[1][SLAB_W] | sb[1][SLAB_W];
    for (int i = 0; i < 2; i++) begin
      if ($signed(sa[i][SLAB_W-1:0]) > $signed(sb[i][SLAB_W-1:0])) begin
        tn1_r[i] <= sb[i][SLAB_W-1:0];
        tf1_r[i] <= sa[i][SLAB_W-1:0];
      end else begin
        tn1_r[i] <= sa[i][SLAB_W-1:0];
        tf1_r[i] <= sb[i][SLAB_W-1:0];
      end
      vn1_r[i] <= fl[i].vneg;
      o21_r[i] <= o2_i[i];
      d1_r[i]  <= d_i[i];
    end

    rej2_r <= vz1_r || nan1_r || (tn1_r[0] > tf1_r[1]) || (tn1_r[1] > tf1_r[0]);
    hn2_r  <= (tn1_r[0] > tn1_r[1]) ? tn1_r[0] : tn1_r[1];
    hf2_r  <= (tf1_r[0] < tf1_r[1]) ? tf1_r[0] : tf1_r[1];
    gt2_r  <= (tn1_r[0] > tn1_r[1]);
    lt2_r  <= (tn1_r[0] < tn1_r[1]);
    for (int i = 0; i < 2; i++) begin
      vn2_r[i] <= vn1_r[i];
      o22_r[i] <= o21_r[i];
      d2_r[i]  <= d1_r[i];
    end

    keep3_r <= keep3;
    hit3_r  <= keep3 && !hn2_r[SLAB_W-1] && (hn2_r < HIT_LIM);
    nx3_r   <= (keep3 && gt2_r) ? (vn2_r[0] ? NRM_POS : NRM_NEG) : NRM_ZERO;
    ny3_r   <= (keep3 && !gt2_r && lt2_r) ? (vn2_r[1] ? NRM_POS : NRM_NEG) : NRM_ZERO;
    tm3_r   <= rej2_r ? '0 : tout;
    tc3_r   <= tc;
    for (int i = 0; i < 2; i++) begin
      o23_r[i] <= o22_r[i];
      d3_r[i]  <= d2_r[i];
    end

    keep4_r <= keep3_r;
    hit4_r  <= hit3_r;
    nx4_r   <= nx3_r;
    ny4_r   <= ny3_r;
    tm4_r   <= tm3_r;
    for (int i = 0; i < 2; i++) begin
      plo4_r[i] <= tc3_r * $signed({1'b0, d3_r[i][DLO_W-1:0]});
      phi4_r[i] <= tc3_r * $signed(d3_r[i][DIR_W-1:DLO_W]);
      o24_r[i]  <= o23_r[i];
    end

    keep5_r <= keep4_r;
    hit5_r  <= hit4_r;
    nx5_r   <= nx4_r;
    ny5_r   <= ny4_r;
    tm5_r   <= tm4_r;
    for (int i = 0; i < 2; i++) begin
      sh5_r[i] <= prod[i][PROD_W-1:TQ_FRAC];
      o25_r[i] <= o24_r[i];
    end

    out_hit        <= hit5_r;
    out_contact_x  <= keep5_r ? cclp[0] : '0;
    out_contact_y  <= keep5_r ? cclp[1] : '0;
    out_normal_x   <= nx5_r;
    out_normal_y   <= ny5_r;
    out_entry_time <= tm5_r;
  end

endmodule

`default_nettype wire

// ----- src/swept_box_vs_box_hit.sv -----
// Top level of the swept box against static box hit test.
// Depends on sbh_pkg, sbh_front, sbh_div and sbh_back.
`default_nettype none

// One box pair is taken on every cycle that start is high; busy never rises, since
// the pipeline runs freely. Each pair gives exactly one result, shown for one cycle
// with out_valid, once it has passed the four front stages, the slab-time dividers,
// which produce one quotient bit per stage, and the six back stages. The receiver
// cannot stall the block and must take each result as it appears.
module swept_box_vs_box_hit import sbh_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [POS_W-1:0]  in_mover_x,
  input  wire logic signed [POS_W-1:0]  in_mover_y,
  input  wire logic [SIZE_W-1:0]        in_mover_w,
  input  wire logic [SIZE_W-1:0]        in_mover_h,
  input  wire logic signed [VEL_W-1:0]  in_vel_x,
  input  wire logic signed [VEL_W-1:0]  in_vel_y,
  input  wire logic signed [BPOS_W-1:0] in_box_x,
  input  wire logic signed [BPOS_W-1:0] in_box_y,
  input  wire logic [BSIZE_W-1:0]       in_box_w,
  input  wire logic [BSIZE_W-1:0]       in_box_h,
  input  wire logic [DT_W-1:0]          in_step_time,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed [CT_W-1:0]        out_contact_x,
  output logic signed [CT_W-1:0]        out_contact_y,
  output logic signed [NRM_W-1:0]       out_normal_x,
  output logic signed [NRM_W-1:0]       out_normal_y,
  output logic signed [TIME_W-1:0]      out_entry_time
);

  localparam int NUM_W = num_width(FRAC_BITS);
  localparam int QW    = NUM_W + TQ_FRAC;

  // free-running pipeline: never holds off a beat
  assign busy = 1'b0;

  item_ctl_t               f_ctl;
  logic [NUM_W-1:0]        f_una [2];
  logic [NUM_W-1:0]        f_unb [2];
  logic [UD_W-1:0]         f_ud  [2];
  logic signed [NUM_W-1:0] f_o2  [2];
  logic signed [DIR_W-1:0] f_d   [2];

  sbh_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .mover_x   (in_mover_x),
    .mover_y   (in_mover_y),
    .mover_w   (in_mover_w),
    .mover_h   (in_mover_h),
    .vel_x     (in_vel_x),
    .vel_y     (in_vel_y),
    .box_x     (in_box_x),
    .box_y     (in_box_y),
    .box_w     (in_box_w),
    .box_h     (in_box_h),
    .step_time (in_step_time),
    .ctl_o     (f_ctl),
    .un_a_o    (f_una),
    .un_b_o    (f_unb),
    .ud_o      (f_ud),
    .o2_o      (f_o2),
    .d_o       (f_d)
  );

  // slab dividers, near and far edge per axis
  logic [QW-1:0] qa [2];
  logic [QW-1:0] qb [2];
  logic          ra [2];
  logic          rb [2];

  for (genvar i = 0; i < 2; i++) begin : g_lane
    sbh_div #(.NUM_W(NUM_W), .QW(QW)) u_div_a (
      .clk      (clk),
      .un_i     (f_una[i]),
      .ud_i     (f_ud[i]),
      .quo_o    (qa[i]),
      .rem_nz_o (ra[i])
    );
    sbh_div #(.NUM_W(NUM_W), .QW(QW)) u_div_b (
      .clk      (clk),
      .un_i     (f_unb[i]),
      .ud_i     (f_ud[i]),
      .quo_o    (qb[i]),
      .rem_nz_o (rb[i])
    );
  end

  // side band delay line matching the divider latency
  logic                    vld_dl [QW];
  logic                    vz_dl  [QW];
  axis_flags_t             ax_dl  [QW];
  axis_flags_t             ay_dl  [QW];
  logic signed [NUM_W-1:0] o2_dl  [QW][2];
  logic signed [DIR_W-1:0] d_dl   [QW][2];
  item_ctl_t               b_ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) begin
        vld_dl[k] <= 1'b0;
      end
    end else begin
      vld_dl[0] <= f_ctl.valid;
      for (int k = 1; k < QW; k++) begin
        vld_dl[k] <= vld_dl[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    vz_dl[0] <= f_ctl.vzero;
    ax_dl[0] <= f_ctl.ax;
    ay_dl[0] <= f_ctl.ay;
    for (int i = 0; i < 2; i++) begin
      o2_dl[0][i] <= f_o2[i];
      d_dl[0][i]  <= f_d[i];
    end
    for (int k = 1; k < QW; k++) begin
      vz_dl[k] <= vz_dl[k-1];
      ax_dl[k] <= ax_dl[k-1];
      ay_dl[k] <= ay_dl[k-1];
      for (int i = 0; i < 2; i++) begin
        o2_dl[k][i] <= o2_dl[k-1][i];
        d_dl[k][i]  <= d_dl[k-1][i];
      end
    end
  end

  assign b_ctl = '{valid: vld_dl[QW-1], vzero: vz_dl[QW-1],
                   ax: ax_dl[QW-1], ay: ay_dl[QW-1]};

  sbh_back #(.NUM_W(NUM_W), .QW(QW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl_i          (b_ctl),
    .qa_i           (qa),
    .ra_i           (ra),
    .qb_i           (qb),
    .rb_i           (rb),
    .o2_i           (o2_dl[QW-1]),
    .d_i            (d_dl[QW-1]),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_contact_x  (out_contact_x),
    .out_contact_y  (out_contact_y),
    .out_normal_x   (out_normal_x),
    .out_normal_y   (out_normal_y),
    .out_entry_time (out_entry_time)
  );

endmodule

`default_nettype wire

// ----- tb/sv/swept_box_vs_box_hit_tb.sv -----
// Self-checking testbench for swept_box_vs_box_hit: directed and random box pairs,
// each result checked against a fixed-point slab-test predictor. Depends on sbh_pkg.
`default_nettype none

module swept_box_vs_box_hit_tb import sbh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB         = FRAC_BITS_DEF;
  localparam int N_RANDOM   = 1100;
  localparam int DRAIN_CYC  = 100;
  localparam longint TBIG_C = longint'(1) << 60;
  localparam longint TINF_C = longint'(1) << 62;
  localparam longint T23_C  = longint'(1) << 23;

  typedef struct {
    logic signed [POS_W-1:0]  mover_x, mover_y;
    logic [SIZE_W-1:0]        mover_w, mover_h;
    logic signed [VEL_W-1:0]  vel_x, vel_y;
    logic signed [BPOS_W-1:0] box_x, box_y;
    logic [BSIZE_W-1:0]       box_w, box_h;
    logic [DT_W-1:0]          step_time;
    bit                       drain_first;  // hold the beat until all results are in
  } pair_t;

  typedef struct {
    logic                     hit;
    logic signed [CT_W-1:0]   contact_x, contact_y;
    logic signed [NRM_W-1:0]  normal_x, normal_y;
    logic signed [TIME_W-1:0] entry_time;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  pair_t cur = '{default: '0};
  logic out_valid, out_hit;
  logic signed [CT_W-1:0] out_contact_x, out_contact_y;
  logic signed [NRM_W-1:0] out_normal_x, out_normal_y;
  logic signed [TIME_W-1:0] out_entry_time;

  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  int       n_sent = 0;
  int       n_total = 0;
  int       errors = 0;
  bit       stim_ready = 1'b0;

  swept_box_vs_box_hit #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mover_x(cur.mover_x), .in_mover_y(cur.mover_y),
    .in_mover_w(cur.mover_w), .in_mover_h(cur.mover_h),
    .in_vel_x(cur.vel_x), .in_vel_y(cur.vel_y),
    .in_box_x(cur.box_x), .in_box_y(cur.box_y),
    .in_box_w(cur.box_w), .in_box_h(cur.box_h),
    .in_step_time(cur.step_time),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_contact_x(out_contact_x), .out_contact_y(out_contact_y),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_entry_time(out_entry_time)
  );

  // Clock and reset
  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // floor(num * 2^31 / d), saturated at 2^60; infinities when d is zero
  function automatic longint slab_entry(longint num, longint d, bit vneg, inout bit nan);
    longint unsigned un, ud, q, r;
    bit neg, sat;
    if (d == 0) begin
      if (num == 0) begin
        nan = 1'b1;
        return 0;
      end
      return ((num < 0) != vneg) ? -TINF_C : TINF_C;
    end
    neg = (num < 0) != (d < 0);
    un = (num < 0) ? longint'(-num) : num;
    ud = (d < 0) ? longint'(-d) : d;
    q = un / ud;
    r = un % ud;
    sat = 1'b0;
    for (int i = 0; i < 31; i++) begin
      if (!sat) begin
        if (q >= TBIG_C) begin
          q = TBIG_C;
          r = 0;
          sat = 1'b1;
        end else begin
          r = r << 1;
          q = q << 1;
          if (r >= ud) begin
            r = r - ud;
            q = q | 1;
          end
        end
      end
    end
    if (q > TBIG_C) q = TBIG_C;
    if (!neg) return longint'(q);
    if (r != 0 && q < TBIG_C) q = q + 1;
    return -longint'(q);
  endfunction

  // One axis: sorted slab times, doubled centre and direction
  function automatic void slab_axis(input longint pos, size, vel, dt, bpos, bsize,
                                    inout bit nan, output longint tn, tf, org2, dir);
    longint one, v, cpos, csize, a, b, t;
    one = longint'(1) << (FB + 1);
    v = bpos * one - size;
    cpos = (v >= 0) ? v / one : -((-v) / one);
    csize = bsize + (size >>> FB);
    org2 = 2 * pos + size;
    dir = vel * dt;
    a = slab_entry(cpos * one - org2, dir, vel < 0, nan);
    b = slab_entry((cpos + csize) * one - org2, dir, vel < 0, nan);
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    tn = a;
    tf = b;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint nx, fx, ny, fy, ox, oy, dx, dy, hn, hf, tc, cx, cy;
    bit nan;
    c = '{default: '0};
    nan = 1'b0;
    if (p.vel_x != 0 || p.vel_y != 0) begin
      slab_axis(longint'(p.mover_x), longint'(p.mover_w), longint'(p.vel_x),
                longint'(p.step_time), longint'(p.box_x), longint'(p.box_w),
                nan, nx, fx, ox, dx);
      slab_axis(longint'(p.mover_y), longint'(p.mover_h), longint'(p.vel_y),
                longint'(p.step_time), longint'(p.box_y), longint'(p.box_h),
                nan, ny, fy, oy, dy);
      if (!nan && !(nx > fy || ny > fx)) begin
        hn = (nx > ny) ? nx : ny;
        hf = (fx < fy) ? fx : fy;
        c.entry_time = TIME_W'(clamp(hn, -T23_C, T23_C - 1));
        if (hf >= 0) begin
          tc = clamp(hn, -T23_C, T23_C);
          cx = (ox + ((tc * dx) >>> 31)) >>> 1;
          cy = (oy + ((tc * dy) >>> 31)) >>> 1;
          c.contact_x = CT_W'(clamp(cx, -T23_C, T23_C - 1));
          c.contact_y = CT_W'(clamp(cy, -T23_C, T23_C - 1));
          // tied entry times leave both normals at zero
          if (nx > ny) c.normal_x = (p.vel_x < 0) ? NRM_POS : NRM_NEG;
          else if (nx < ny) c.normal_y = (p.vel_y < 0) ? NRM_POS : NRM_NEG;
          c.hit = (hn >= 0 && hn < 65536);
        end
      end
    end
    return c;
  endfunction

  function automatic pair_t full_random_pair();
    pair_t p;
    p.mover_x = POS_W'($urandom);    p.mover_y = POS_W'($urandom);
    p.mover_w = SIZE_W'($urandom);   p.mover_h = SIZE_W'($urandom);
    p.vel_x = VEL_W'($urandom);      p.vel_y = VEL_W'($urandom);
    p.box_x = BPOS_W'($urandom);     p.box_y = BPOS_W'($urandom);
    p.box_w = BSIZE_W'($urandom);    p.box_h = BSIZE_W'($urandom);
    p.step_time = DT_W'($urandom);
    p.drain_first = 1'b0;
    return p;
  endfunction

  // Box placed somewhere along, or just past, the mover's path on one axis
  function automatic void aimed_axis(output logic signed [POS_W-1:0] m,
                                     output logic [SIZE_W-1:0] sz,
                                     output logic signed [VEL_W-1:0] v,
                                     output logic signed [BPOS_W-1:0] b,
                                     output logic [BSIZE_W-1:0] bs,
                                     input longint dt);
    longint mm, vv, travel, target;
    mm = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    vv = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    if ($urandom_range(0, 9) == 0) vv = 0;
    travel = (vv * dt) >>> 16;
    target = mm + (travel * longint'($urandom_range(0, 150))) / 100;
    m = POS_W'(mm);
    v = VEL_W'(vv);
    sz = SIZE_W'($urandom_range(0, 1 << $urandom_range(4, 14)));
    b = BPOS_W'(clamp(target >>> FB, -32768, 32767) - longint'($urandom_range(0, 8)));
    bs = BSIZE_W'($urandom_range(0, 1 << $urandom_range(2, 9)));
  endfunction

  function automatic pair_t aimed_pair();
    pair_t p;
    p.step_time = DT_W'($urandom);
    aimed_axis(p.mover_x, p.mover_w, p.vel_x, p.box_x, p.box_w, longint'(p.step_time));
    aimed_axis(p.mover_y, p.mover_h, p.vel_y, p.box_y, p.box_h, longint'(p.step_time));
    p.drain_first = 1'b0;
    return p;
  endfunction

  function automatic pair_t mk(longint mx, my, mw, mh, vx, vy, bx, by, bw, bh, dt);
    pair_t p;
    p.mover_x = POS_W'(mx);  p.mover_y = POS_W'(my);
    p.mover_w = SIZE_W'(mw); p.mover_h = SIZE_W'(mh);
    p.vel_x = VEL_W'(vx);    p.vel_y = VEL_W'(vy);
    p.box_x = BPOS_W'(bx);   p.box_y = BPOS_W'(by);
    p.box_w = BSIZE_W'(bw);  p.box_h = BSIZE_W'(bh);
    p.step_time = DT_W'(dt);
    p.drain_first = 1'b0;
    return p;
  endfunction

  // append one pair to the stimulus queue
  function automatic void queue_pair(pair_t p);
    pending_pairs = {pending_pairs, p};
  endfunction

  // Stimulus: directed corners first, then mostly aimed pairs with some noise
  initial begin
    pair_t p;
    queue_pair(mk(0, 0, 256, 256, 0, 0, 5, 5, 2, 2, 65535));       // still
    queue_pair(mk(0, 0, 256, 256, 2560, 0, 5, 0, 2, 2, 32768));    // head on x
    queue_pair(mk(0, 0, 256, 256, 0, 2560, 0, 5, 2, 2, 32768));    // head on y
    queue_pair(mk(0, 0, 256, 256, 2560, 2560, 5, 5, 2, 2, 32768)); // tie
    queue_pair(mk(0, 0, 256, 256, -2560, 0, 5, 0, 2, 2, 65535));   // behind
    queue_pair(mk(0, 0, 256, 256, 2560, 0, 5, 40, 2, 2, 65535));   // miss
    queue_pair(mk(0, 0, 0, 0, 256, 0, 0, 0, 0, 0, 65535));         // 0/0 edge
    queue_pair(mk(0, 0, 256, 256, 256, 0, 50, 0, 2, 2, 65535));    // too far
    queue_pair(mk(0, 0, 256, 256, 2560, 0, 5, 0, 2, 2, 0));        // zero step
    queue_pair(mk(-8388608, -8388608, 0, 0, 8388607, 8388607,
                  32767, 32767, 32767, 32767, 65535));
    queue_pair(mk(8388607, 8388607, 8388607, 8388607, -8388608, -8388608,
                  -32768, -32768, 0, 0, 65535));
    queue_pair(mk(8388607, -8388608, 8388607, 0, -8388608, 8388607,
                  -32768, 32767, 32767, 0, 1));
    queue_pair(mk(0, 0, 8388607, 8388607, 1, -1, 0, 0, 32767, 32767, 65535));
    queue_pair(mk(1280, 1280, 512, 512, -1, 0, 5, 5, 2, 2, 1));    // inside
    queue_pair(mk(0, 0, 256, 256, 1, 1, 5, 5, 2, 2, 1));
    queue_pair(mk(-8388608, 0, 0, 0, 8388607, 0, 32767, -1, 0, 2, 65535));
    p = mk(0, 0, 384, 384, 2560, -2560, 5, -5, 3, 3, 40000);
    p.drain_first = 1'b1;
    queue_pair(p);
    for (int i = 0; i < N_RANDOM; i++) begin
      p = ($urandom_range(0, 99) < 80) ? aimed_pair() : full_random_pair();
      p.drain_first = (i == N_RANDOM / 2);
      queue_pair(p);
    end
    n_total = pending_pairs.size();
    stim_ready = 1'b1;
  end

  // Driver: one beat per accepted pair; idle rate by phase of the run
  always @(posedge clk) begin
    bit go;
    int idle_pct;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_contacts = {expected_contacts, predict_contact(cur)};
        n_sent = n_sent + 1;
      end
      if (!(start && busy)) begin
        idle_pct = (n_sent < n_total / 3) ? 30 : ((n_sent < 2 * n_total / 3) ? 70 : 0);
        go = stim_ready && pending_pairs.size() > 0 && $urandom_range(0, 99) >= idle_pct;
        if (go && pending_pairs[0].drain_first &&
            (expected_contacts.size() > 0 || (start && !busy)))
          go = 1'b0;
        if (go) begin
          cur <= pending_pairs.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  // Monitor: each result beat against the oldest expectation
  always @(posedge clk) begin
    contact_t e;
    if (rst_n && out_valid) begin
      if (expected_contacts.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected", $realtime);
      end else begin
        e = expected_contacts.pop_front();
        check_field("hit", e.hit, out_hit);
        check_field("contact_x", e.contact_x, out_contact_x);
        check_field("contact_y", e.contact_y, out_contact_y);
        check_field("normal_x", e.normal_x, out_normal_x);
        check_field("normal_y", e.normal_y, out_normal_y);
        check_field("entry_time", e.entry_time, out_entry_time);
      end
    end
  end

  // End of run
  initial begin
    wait (stim_ready);
    @(posedge clk);
    while (pending_pairs.size() > 0 || start || expected_contacts.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && expected_contacts.size() == 0)
      $display("swept_box_vs_box_hit_tb: done, clean");
    else
      $display("swept_box_vs_box_hit_tb: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("swept_box_vs_box_hit_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
